/* hw/rtl/bff_pkg.sv */
package bff_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4096;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int PixW      = 24;

  localparam logic [1:0] ModeGray    = 2'd0;
  localparam logic [1:0] ModeSharp   = 2'd1;
  localparam logic [1:0] ModeDenoise = 2'd2;

  localparam logic [1:0] RegMode   = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdFlush = 1'b1;

  // floor(x / 1000) = (x * GrayRecip) >> GrayShift for x <= 255000
  localparam logic [18:0] GrayRecip = 19'd268436;
  localparam int          GrayShift = 28;
  // floor(x / 9) = (x * BoxRecip) >> BoxShift for x <= 2295
  localparam logic [11:0] BoxRecip  = 12'd3641;
  localparam int          BoxShift  = 15;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [11:0] width;
    logic [12:0] height;
  } geom_t;

  typedef struct packed {
    logic [PixW-1:0]  centre;
    logic [17:0]      gray_sum;
    logic [2:0][11:0] sharp;
    logic [2:0][11:0] box_sum;
    logic             interior;
    logic             eof;
  } calc_t;

endpackage

/* hw/rtl/bff_ram.sv */
module bff_ram #(
  parameter int Width = 24,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bff_front.sv */
module bff_front import bff_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  geom_t    geom_i,
  input  logic     restart_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     calc_ready_i,
  output logic     calc_valid_o,
  output calc_t    calc_o
);

  typedef struct packed {
    logic             pixel;
    logic             emit;
    logic             interior;
    logic             eof;
    logic             sel_mid;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  px;
    logic             fwd;
    logic [PixW-1:0]  fwd_up;
    logic [PixW-1:0]  fwd_mid;
  } s1_t;

  logic [AddrW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [11:0]      in_row_q, in_row_d, out_row_q, out_row_d;
  logic [11:0]      pend_q, pend_d;
  logic [11:0]      in_col_inc, out_col_inc, w_m1;
  logic [12:0]      in_row_inc, out_row_inc;
  logic             draining, is_flush, accept, take, emit;
  logic [AddrW-1:0] rd_addr;

  logic             s1_v_q;
  s1_t              s1_q, s1_d;
  logic             s1_go;

  logic [PixW-1:0]  up_rdata, mid_rdata, up_rd, mid_rd;
  logic [8:0][PixW-1:0] win_q, win_n;

  assign in_col_inc  = {1'b0, in_col_q} + 12'd1;
  assign out_col_inc = {1'b0, out_col_q} + 12'd1;
  assign in_row_inc  = {1'b0, in_row_q} + 13'd1;
  assign out_row_inc = {1'b0, out_row_q} + 13'd1;
  assign w_m1        = geom_i.width - 12'd1;

  assign draining = (in_row_q == '0) && (in_col_q == '0) && (pend_q != '0);
  assign is_flush = in_item_i.cmd == CmdFlush;
  assign s1_go    = s1_v_q && (!s1_q.emit || calc_ready_i);
  assign in_stall_o = s1_v_q && !s1_go;
  assign accept   = in_valid_i && !in_stall_o;
  assign take     = is_flush ? draining : !draining;
  assign emit     = is_flush || (pend_q > geom_i.width);

  always_comb begin
    if (is_flush) begin
      rd_addr = ({1'b0, out_col_q} >= geom_i.width) ? w_m1[AddrW-1:0] : out_col_q;
    end else begin
      rd_addr = in_col_q;
    end
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pend_d    = pend_q;
    if (!is_flush) begin
      if (in_col_inc >= geom_i.width) begin
        in_col_d = '0;
        in_row_d = (in_row_inc >= geom_i.height) ? '0 : in_row_inc[11:0];
      end else begin
        in_col_d = in_col_inc[AddrW-1:0];
      end
      if (!emit) begin
        pend_d = pend_q + 12'd1;
      end
    end else begin
      pend_d = pend_q - 12'd1;
    end
    if (emit) begin
      if (out_col_inc >= geom_i.width) begin
        out_col_d = '0;
        out_row_d = (out_row_inc >= geom_i.height) ? '0 : out_row_inc[11:0];
      end else begin
        out_col_d = out_col_inc[AddrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
    end else if (restart_i) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
    end else if (accept && take) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pend_q    <= pend_d;
    end
  end

  bff_ram #(.Width(PixW), .Depth(MaxWidth)) u_ram_upper (
    .clk_i   (clk_i),
    .we_i    (s1_go && s1_q.pixel),
    .waddr_i (s1_q.addr),
    .wdata_i (mid_rd),
    .re_i    (accept && take),
    .raddr_i (rd_addr),
    .rdata_o (up_rdata)
  );

  bff_ram #(.Width(PixW), .Depth(MaxWidth)) u_ram_middle (
    .clk_i   (clk_i),
    .we_i    (s1_go && s1_q.pixel),
    .waddr_i (s1_q.addr),
    .wdata_i (s1_q.px),
    .re_i    (accept && take),
    .raddr_i (rd_addr),
    .rdata_o (mid_rdata)
  );

  assign up_rd  = s1_q.fwd ? s1_q.fwd_up  : up_rdata;
  assign mid_rd = s1_q.fwd ? s1_q.fwd_mid : mid_rdata;

  always_comb begin
    s1_d.pixel    = !is_flush;
    s1_d.emit     = emit;
    s1_d.interior = !is_flush && (out_row_q != '0) && (out_row_inc < geom_i.height)
                    && (out_col_q != '0) && (out_col_inc < geom_i.width);
    s1_d.eof      = (out_row_inc == geom_i.height) && (out_col_inc == geom_i.width);
    s1_d.sel_mid  = out_row_inc >= geom_i.height;
    s1_d.addr     = rd_addr;
    s1_d.px       = {in_item_i.in_red, in_item_i.in_green, in_item_i.in_blue};
    // catch a line store write landing in the same cycle as this read
    s1_d.fwd      = s1_go && s1_q.pixel && (s1_q.addr == rd_addr);
    s1_d.fwd_up   = mid_rd;
    s1_d.fwd_mid  = s1_q.px;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_v_q <= accept && take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && take) begin
      s1_q <= s1_d;
    end
  end

  always_comb begin
    win_n    = win_q;
    win_n[0] = win_q[1];
    win_n[1] = win_q[2];
    win_n[2] = up_rd;
    win_n[3] = win_q[4];
    win_n[4] = win_q[5];
    win_n[5] = mid_rd;
    win_n[6] = win_q[7];
    win_n[7] = win_q[8];
    win_n[8] = s1_q.px;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (restart_i) begin
      win_q <= '0;
    end else if (s1_go && s1_q.pixel) begin
      win_q <= win_n;
    end
  end

  always_comb begin
    calc_o.centre   = s1_q.pixel ? win_q[5] : (s1_q.sel_mid ? mid_rd : up_rd);
    calc_o.gray_sum = 18'd114 * {10'b0, calc_o.centre[7:0]}
                    + 18'd587 * {10'b0, calc_o.centre[15:8]}
                    + 18'd299 * {10'b0, calc_o.centre[23:16]};
    for (int k = 0; k < 3; k++) begin
      calc_o.sharp[k] = {2'b0, win_n[4][8*k +: 8], 2'b0} + {4'b0, win_n[4][8*k +: 8]}
                      - {4'b0, win_n[1][8*k +: 8]} - {4'b0, win_n[3][8*k +: 8]}
                      - {4'b0, win_n[5][8*k +: 8]} - {4'b0, win_n[7][8*k +: 8]};
      calc_o.box_sum[k] = ({4'b0, win_n[0][8*k +: 8]} + {4'b0, win_n[1][8*k +: 8]}
                         + {4'b0, win_n[2][8*k +: 8]})
                        + ({4'b0, win_n[3][8*k +: 8]} + {4'b0, win_n[4][8*k +: 8]}
                         + {4'b0, win_n[5][8*k +: 8]})
                        + ({4'b0, win_n[6][8*k +: 8]} + {4'b0, win_n[7][8*k +: 8]}
                         + {4'b0, win_n[8][8*k +: 8]});
    end
    calc_o.interior = s1_q.interior;
    calc_o.eof      = s1_q.eof;
  end

  assign calc_valid_o = s1_v_q && s1_q.emit && calc_ready_i;

endmodule

/* hw/rtl/bff_back.sv */
module bff_back import bff_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [1:0] mode_i,
  input  logic      calc_valid_i,
  output logic      calc_ready_o,
  input  calc_t     calc_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic             s2_v_q, out_v_q, out_rdy;
  calc_t            s2_q;
  out_item_t        out_q, out_d;
  logic [36:0]      gray_prod;
  logic [2:0][23:0] box_prod;
  logic [2:0][7:0]  res, sharp_cl, box_q9;

  assign out_rdy      = !out_v_q || !out_stall_i;
  assign calc_ready_o = !s2_v_q || out_rdy;

  always_comb begin
    gray_prod = {19'b0, s2_q.gray_sum} * {18'b0, GrayRecip};
    for (int k = 0; k < 3; k++) begin
      box_prod[k] = {12'b0, s2_q.box_sum[k]} * {12'b0, BoxRecip};
      box_q9[k]   = box_prod[k][BoxShift +: 8];
      if (s2_q.sharp[k][11]) begin
        sharp_cl[k] = 8'd0;
      end else if (s2_q.sharp[k][10:8] != 3'd0) begin
        sharp_cl[k] = 8'd255;
      end else begin
        sharp_cl[k] = s2_q.sharp[k][7:0];
      end
    end
    for (int k = 0; k < 3; k++) begin
      case (mode_i)
        ModeGray:    res[k] = gray_prod[GrayShift +: 8];
        ModeSharp:   res[k] = s2_q.interior ? sharp_cl[k] : s2_q.centre[8*k +: 8];
        ModeDenoise: res[k] = s2_q.interior ? box_q9[k] : s2_q.centre[8*k +: 8];
        default:     res[k] = s2_q.centre[8*k +: 8];
      endcase
    end
    out_d.out_blue     = res[0];
    out_d.out_green    = res[1];
    out_d.out_red      = res[2];
    out_d.end_of_frame = s2_q.eof;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (calc_ready_o) begin
        s2_v_q <= calc_valid_i;
      end
      if (out_rdy) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (calc_ready_o && calc_valid_i) begin
      s2_q <= calc_i;
    end
    if (out_rdy && s2_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

/* hw/rtl/bgr_frame_filter_3x3_unit.sv */
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_stall_o   in_item_i  (cmd, in_blue/green/red)
// out       output     out_valid_o/out_stall_i out_item_o (out_blue/green/red, end_of_frame)
// config    input      psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// One item per cycle while in_stall_o is low. A result passes the s1, s2 and output
// registers; the line store read is registered, sums and a weighted gray sum
// follow, then the reciprocal multiplies and clamps feed the output register.
// Reset clears counters, window and pipeline valids; line store contents stay undefined.
// in_stall_o rises only when all stages downstream are full and out_stall_i is high.
module bgr_frame_filter_3x3_unit import bff_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  mode_q;
  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [1:0]  reg_idx;
  logic        wr, restart;
  geom_t       geom;
  logic        calc_valid, calc_ready;
  calc_t       calc;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite && pready;
  assign restart = wr && (reg_idx inside {RegWidth, RegHeight});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeGray;
      width_q  <= 12'd640;
      height_q <= 13'd480;
    end else if (wr) begin
      case (reg_idx)
        RegMode:   mode_q   <= pwdata[1:0];
        RegWidth:  width_q  <= pwdata[11:0];
        RegHeight: height_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegMode:   prdata = {30'b0, mode_q};
      RegWidth:  prdata = {20'b0, width_q};
      RegHeight: prdata = {19'b0, height_q};
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    if (width_q == '0) begin
      geom.width = 12'd1;
    end else if (width_q > 12'(MaxWidth)) begin
      geom.width = 12'(MaxWidth);
    end else begin
      geom.width = width_q;
    end
    if (height_q == '0) begin
      geom.height = 13'd1;
    end else if (height_q > 13'(MaxHeight)) begin
      geom.height = 13'(MaxHeight);
    end else begin
      geom.height = height_q;
    end
  end

  bff_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .restart_i    (restart),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .calc_ready_i (calc_ready),
    .calc_valid_o (calc_valid),
    .calc_o       (calc)
  );

  bff_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .calc_valid_i (calc_valid),
    .calc_ready_o (calc_ready),
    .calc_i       (calc),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

/* hw/rtl/bff_checker.sv */
module bff_checker import bff_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // output held while stalled
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("out_valid_o dropped while stalled");

  a_out_item_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("out_item_o changed while stalled");

  // input backpressure only arises from a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("in_stall_o high without a stalled output");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("activity during reset");

endmodule

bind bgr_frame_filter_3x3_unit bff_checker u_bff_checker (.*);
